// File: hw/rtl/upmx_pkg.sv
package upmx_pkg;

  localparam int unsigned SMP_W  = 32;
  localparam int unsigned ACC_W  = 36;   // five doubled Q31 products, exact
  localparam int unsigned PC_W   = 4;
  localparam int unsigned FILT_W = 3;
  localparam int unsigned NUM_FILT = 5;
  localparam int unsigned NUM_TAPS = 4;

  typedef logic signed [SMP_W-1:0] q31_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic [PC_W-1:0]         pc_t;
  typedef logic [FILT_W-1:0]       filt_t;

  // multiplier A operand
  localparam logic A_GAIN = 1'b0;
  localparam logic A_COEF = 1'b1;

  // multiplier B operand
  localparam logic [2:0] B_IN_L = 3'd0;
  localparam logic [2:0] B_RX   = 3'd1;
  localparam logic [2:0] B_X    = 3'd2;
  localparam logic [2:0] B_T0   = 3'd3;
  localparam logic [2:0] B_T1   = 3'd4;
  localparam logic [2:0] B_T2   = 3'd5;
  localparam logic [2:0] B_T3   = 3'd6;

  // accumulator ops on the registered product
  localparam logic [1:0] ACC_HOLD = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;
  localparam logic [1:0] ACC_SUB  = 2'd3;

  // filter pointer ops
  localparam logic [1:0] FP_HOLD  = 2'd0;
  localparam logic [1:0] FP_FIRST = 2'd1;
  localparam logic [1:0] FP_NEXT  = 2'd2;

  // sequencer jumps
  localparam logic [2:0] JMP_NONE     = 3'd0;
  localparam logic [2:0] JMP_WAIT_IN  = 3'd1;
  localparam logic [2:0] JMP_PASS     = 3'd2;
  localparam logic [2:0] JMP_LOOP     = 3'd3;
  localparam logic [2:0] JMP_WAIT_OUT = 3'd4;
  localparam logic [2:0] JMP_RESTART  = 3'd5;

  // coefficient indexes
  localparam logic [2:0] C_A0 = 3'd0;
  localparam logic [2:0] C_A1 = 3'd1;
  localparam logic [2:0] C_A2 = 3'd2;
  localparam logic [2:0] C_B1 = 3'd3;
  localparam logic [2:0] C_B2 = 3'd4;

  // program addresses
  localparam pc_t STEP_IDLE = 4'd0;
  localparam pc_t STEP_MAC0 = 4'd3;
  localparam pc_t STEP_DONE = 4'd10;

  // filter ids, also tap memory rows
  localparam filt_t F_HPL = 3'd0;
  localparam filt_t F_LPL = 3'd1;
  localparam filt_t F_LPC = 3'd2;
  localparam filt_t F_HPR = 3'd3;
  localparam filt_t F_LPR = 3'd4;

  // result destinations
  localparam logic [1:0] DST_FL  = 2'd0;
  localparam logic [1:0] DST_FR  = 2'd1;
  localparam logic [1:0] DST_CTR = 2'd2;

  typedef struct packed {
    logic       a_sel;
    logic [2:0] c_idx;
    logic [2:0] b_sel;
    logic [1:0] acc_op;
    logic       st_sl;
    logic       st_sr;
    logic       wb;
    logic [1:0] fp_op;
    logic [2:0] jmp;
  } ctl_t;

  typedef struct packed {
    logic in_ready;
    logic out_load;
  } seq_stat_t;

  function automatic ctl_t ucode(input pc_t pc);
    ctl_t w;
    w = '{a_sel: A_GAIN, c_idx: C_A0, b_sel: B_X, acc_op: ACC_HOLD, st_sl: 1'b0,
          st_sr: 1'b0, wb: 1'b0, fp_op: FP_HOLD, jmp: JMP_NONE};
    unique case (pc)
      4'd0: begin w.b_sel = B_IN_L; w.jmp = JMP_WAIT_IN; end
      4'd1: begin w.b_sel = B_RX; w.st_sl = 1'b1; end
      4'd2: begin w.st_sr = 1'b1; w.fp_op = FP_FIRST; w.jmp = JMP_PASS; end
      4'd3: begin w.a_sel = A_COEF; w.c_idx = C_A0; w.b_sel = B_X; end
      4'd4: begin
        w.a_sel = A_COEF; w.c_idx = C_A1; w.b_sel = B_T0; w.acc_op = ACC_LOAD;
      end
      4'd5: begin
        w.a_sel = A_COEF; w.c_idx = C_A2; w.b_sel = B_T1; w.acc_op = ACC_ADD;
      end
      4'd6: begin
        w.a_sel = A_COEF; w.c_idx = C_B1; w.b_sel = B_T2; w.acc_op = ACC_ADD;
      end
      4'd7: begin
        w.a_sel = A_COEF; w.c_idx = C_B2; w.b_sel = B_T3; w.acc_op = ACC_SUB;
      end
      4'd8: begin w.acc_op = ACC_SUB; end
      4'd9: begin w.wb = 1'b1; w.fp_op = FP_NEXT; w.jmp = JMP_LOOP; end
      4'd10: begin w.jmp = JMP_WAIT_OUT; end
      default: begin w.jmp = JMP_RESTART; end
    endcase
    return w;
  endfunction

  // halved coefficients, Q1.31
  function automatic q31_t coef(input logic lp, input logic [2:0] idx);
    q31_t c;
    c = '0;
    if (lp) begin
      case (idx)
        C_A0, C_A2: c = 32'sd4952781;
        C_A1:       c = 32'sd9905562;
        C_B1:       c = -32'sd1931765060;
        C_B2:       c = 32'sd877797259;
        default:    c = '0;
      endcase
    end else begin
      case (idx)
        C_A0, C_A2: c = 32'sd1020910595;
        C_A1:       c = -32'sd2041821189;
        C_B1:       c = -32'sd2039393731;
        C_B2:       c = 32'sd970837673;
        default:    c = '0;
      endcase
    end
    return c;
  endfunction

  function automatic filt_t filt_first(input logic lp);
    return lp ? F_LPL : F_HPL;
  endfunction

  function automatic filt_t filt_next(input filt_t f);
    filt_t n;
    case (f)
      F_LPL:   n = F_LPC;
      F_LPC:   n = F_LPR;
      F_HPL:   n = F_HPR;
      default: n = f;
    endcase
    return n;
  endfunction

  function automatic logic filt_last(input filt_t f);
    return (f == F_LPR) || (f == F_HPR);
  endfunction

  function automatic logic filt_is_lp(input filt_t f);
    logic r;
    case (f) inside
      F_LPL, F_LPC, F_LPR: r = 1'b1;
      default:             r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic filt_uses_right(input filt_t f);
    return (f == F_HPR) || (f == F_LPR);
  endfunction

  function automatic logic [1:0] filt_dest(input filt_t f);
    logic [1:0] d;
    case (f) inside
      F_LPL, F_HPL: d = DST_FL;
      F_LPC:        d = DST_CTR;
      default:      d = DST_FR;
    endcase
    return d;
  endfunction

endpackage

// File: hw/rtl/upmx_seq.sv
// Program counter, control ROM and filter pointer.
module upmx_seq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   out_free,
  input  logic                   mode_lp,
  input  logic                   mode_pass,
  output upmx_pkg::ctl_t         ctl,
  output upmx_pkg::filt_t        fp,
  output upmx_pkg::filt_t        rd_row,
  output upmx_pkg::seq_stat_t    stat
);

  upmx_pkg::pc_t   pc_r, pc_nxt;
  upmx_pkg::filt_t fp_r, fp_nxt;
  upmx_pkg::ctl_t  word;

  assign word = upmx_pkg::ucode(pc_r);

  always_comb begin
    pc_nxt = pc_r + upmx_pkg::pc_t'(1);
    stat.in_ready = 1'b0;
    stat.out_load = 1'b0;
    unique case (word.jmp)
      upmx_pkg::JMP_NONE: ;
      upmx_pkg::JMP_WAIT_IN: begin
        stat.in_ready = 1'b1;
        if (!in_valid) pc_nxt = pc_r;
      end
      upmx_pkg::JMP_PASS: begin
        if (mode_pass) pc_nxt = upmx_pkg::STEP_DONE;
      end
      upmx_pkg::JMP_LOOP: begin
        if (!upmx_pkg::filt_last(fp_r)) pc_nxt = upmx_pkg::STEP_MAC0;
      end
      upmx_pkg::JMP_WAIT_OUT: begin
        if (out_free) begin
          stat.out_load = 1'b1;
          pc_nxt = upmx_pkg::STEP_IDLE;
        end else begin
          pc_nxt = pc_r;
        end
      end
      default: pc_nxt = upmx_pkg::STEP_IDLE;
    endcase
  end

  always_comb begin
    unique case (word.fp_op)
      upmx_pkg::FP_FIRST: fp_nxt = upmx_pkg::filt_first(mode_lp);
      upmx_pkg::FP_NEXT:  fp_nxt = upmx_pkg::filt_next(fp_r);
      default:            fp_nxt = fp_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= upmx_pkg::STEP_IDLE;
      fp_r <= upmx_pkg::F_HPL;
    end else begin
      pc_r <= pc_nxt;
      fp_r <= fp_nxt;
    end
  end

  assign ctl    = word;
  assign fp     = fp_r;
  assign rd_row = fp_nxt;

endmodule

// File: hw/rtl/upmx_dp.sv
// Shared 32x32 multiplier, accumulator, tap memory and result registers.
module upmx_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  upmx_pkg::ctl_t   ctl,
  input  upmx_pkg::filt_t  fp,
  input  upmx_pkg::filt_t  rd_row,
  input  logic             in_accept,
  input  upmx_pkg::q31_t   in_left,
  input  upmx_pkg::q31_t   in_right,
  input  upmx_pkg::q31_t   gain,
  output upmx_pkg::q31_t   sl,
  output upmx_pkg::q31_t   sr,
  output upmx_pkg::q31_t   fl,
  output upmx_pkg::q31_t   fr,
  output upmx_pkg::q31_t   ctr
);

  typedef logic [upmx_pkg::NUM_TAPS-1:0][upmx_pkg::SMP_W-1:0] tap_row_t;

  localparam upmx_pkg::q31_t Q_MAX = 32'sh7fff_ffff;
  localparam upmx_pkg::q31_t Q_MIN = 32'sh8000_0000;

  tap_row_t tap_mem [upmx_pkg::NUM_FILT];
  logic [upmx_pkg::NUM_FILT-1:0] tap_vld_r;
  tap_row_t row_r;

  upmx_pkg::q31_t rx_r, sl_r, sr_r, fl_r, fr_r, ctr_r, prod_r, prod_nxt;
  upmx_pkg::acc_t acc_r, acc_nxt, prod2;
  upmx_pkg::q31_t mul_a, mul_b, x, y;
  logic signed [2*upmx_pkg::SMP_W-1:0] prod_full;
  logic signed [upmx_pkg::SMP_W:0]     prod_sh;

  assign x = upmx_pkg::filt_uses_right(fp) ? sr_r : sl_r;

  always_comb begin
    mul_a = (ctl.a_sel == upmx_pkg::A_COEF) ?
            upmx_pkg::coef(upmx_pkg::filt_is_lp(fp), ctl.c_idx) : gain;
    case (ctl.b_sel)
      upmx_pkg::B_IN_L: mul_b = in_left;
      upmx_pkg::B_RX:   mul_b = rx_r;
      upmx_pkg::B_T0:   mul_b = upmx_pkg::q31_t'(row_r[0]);
      upmx_pkg::B_T1:   mul_b = upmx_pkg::q31_t'(row_r[1]);
      upmx_pkg::B_T2:   mul_b = upmx_pkg::q31_t'(row_r[2]);
      upmx_pkg::B_T3:   mul_b = upmx_pkg::q31_t'(row_r[3]);
      default:          mul_b = x;
    endcase
  end

  // floor(a*b / 2^31), saturated; only -1 * -1 overflows
  always_comb begin
    prod_full = mul_a * mul_b;
    prod_sh   = prod_full[2*upmx_pkg::SMP_W-1:upmx_pkg::SMP_W-1];
    if (prod_sh[upmx_pkg::SMP_W] != prod_sh[upmx_pkg::SMP_W-1])
      prod_nxt = prod_sh[upmx_pkg::SMP_W] ? Q_MIN : Q_MAX;
    else
      prod_nxt = prod_sh[upmx_pkg::SMP_W-1:0];
  end

  assign prod2 = {{(upmx_pkg::ACC_W-upmx_pkg::SMP_W-1){prod_r[upmx_pkg::SMP_W-1]}},
                  prod_r, 1'b0};

  always_comb begin
    case (ctl.acc_op)
      upmx_pkg::ACC_LOAD: acc_nxt = prod2;
      upmx_pkg::ACC_ADD:  acc_nxt = acc_r + prod2;
      upmx_pkg::ACC_SUB:  acc_nxt = acc_r - prod2;
      default:            acc_nxt = acc_r;
    endcase
  end

  always_comb begin
    if (&acc_r[upmx_pkg::ACC_W-1:upmx_pkg::SMP_W-1] ||
        ~|acc_r[upmx_pkg::ACC_W-1:upmx_pkg::SMP_W-1])
      y = acc_r[upmx_pkg::SMP_W-1:0];
    else
      y = acc_r[upmx_pkg::ACC_W-1] ? Q_MIN : Q_MAX;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_vld_r <= '0;
    end else if (ctl.wb) begin
      tap_vld_r[fp] <= 1'b1;
    end
  end

  // taps per row: x(n-1), x(n-2), y(n-1), y(n-2); invalid rows read zero
  always_ff @(posedge clk) begin
    row_r <= tap_vld_r[rd_row] ? tap_mem[rd_row] : '0;
    if (ctl.wb) begin
      tap_mem[fp] <= {row_r[2], y, row_r[0], x};
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    if (in_accept) rx_r <= in_right;
    if (ctl.st_sl) sl_r <= prod_r;
    if (ctl.st_sr) sr_r <= prod_r;
    if (ctl.wb) begin
      case (upmx_pkg::filt_dest(fp))
        upmx_pkg::DST_FL:  fl_r  <= y;
        upmx_pkg::DST_CTR: ctr_r <= y;
        default:           fr_r  <= y;
      endcase
    end
  end

  assign sl  = sl_r;
  assign sr  = sr_r;
  assign fl  = fl_r;
  assign fr  = fr_r;
  assign ctr = ctr_r;

endmodule

// File: hw/rtl/stereo_to_five_channel_biquad_upmix_unit.sv
// Stereo to five-channel upmixer. One transaction on the in_ side carries a stereo
// Q1.31 frame; one transaction on the out_ side returns front left, front right,
// center, surround left and surround right. Both inputs are scaled by input_gain
// (surrounds carry the scaled values). Lowpass mode runs three direct-form-1
// biquads (left, center, right), highpass mode two, pass mode none. Every
// multiply goes through a single 32x32 multiplier driven by a microcoded
// sequencer, one multiply per cycle unless the sequencer waits for a frame
// or for the output register. A finished result waits in the output
// register while the next frame is already being worked on. Filter taps
// persist across mode changes.
// Configuration: index 0 filter_enable_lowpass, 1 bypass_highpass,
// 2 input_gain; index 3 is ignored. Write configuration only while idle.
module stereo_to_five_channel_biquad_upmix_unit #(
  parameter int SAMPLE_BITS = 32   // 16..32; output LSBs below this are cleared
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // left_sample, right_sample
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata,  // front_left, front_right, center_out,
                                   // surround_left, surround_right
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam logic [1:0] REG_LOWPASS = 2'd0;
  localparam logic [1:0] REG_BYPASS  = 2'd1;
  localparam logic [1:0] REG_GAIN    = 2'd2;

  localparam logic [31:0] OUT_MASK = ~((32'd1 << (32 - SAMPLE_BITS)) - 32'd1);

  // config registers
  logic           lp_r, byp_r;
  upmx_pkg::q31_t gain_r;
  logic           mode_pass;

  upmx_pkg::ctl_t      ctl;
  upmx_pkg::filt_t     fp, rd_row;
  upmx_pkg::seq_stat_t stat;

  upmx_pkg::q31_t sl, sr, fl, fr, ctr;
  logic           in_accept, out_free;

  logic           out_vld_r;
  logic [159:0]   out_data_r, out_data_nxt;

  assign cfg_ready = 1'b1;
  assign mode_pass = !lp_r && byp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_r   <= 1'b1;
      byp_r  <= 1'b0;
      gain_r <= 32'sh4000_0000;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LOWPASS: lp_r   <= cfg_data[0];
        REG_BYPASS:  byp_r  <= cfg_data[0];
        REG_GAIN:    gain_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_tready = stat.in_ready;
  assign in_accept = in_tvalid && stat.in_ready;
  assign out_free  = !out_vld_r || out_tready;

  upmx_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .out_free  (out_free),
    .mode_lp   (lp_r),
    .mode_pass (mode_pass),
    .ctl       (ctl),
    .fp        (fp),
    .rd_row    (rd_row),
    .stat      (stat)
  );

  upmx_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .fp        (fp),
    .rd_row    (rd_row),
    .in_accept (in_accept),
    .in_left   (in_tdata[31:0]),
    .in_right  (in_tdata[63:32]),
    .gain      (gain_r),
    .sl        (sl),
    .sr        (sr),
    .fl        (fl),
    .fr        (fr),
    .ctr       (ctr)
  );

  // pass mode forwards scaled samples; center is zero outside lowpass
  always_comb begin
    out_data_nxt[31:0]    = (mode_pass ? sl : fl) & OUT_MASK;
    out_data_nxt[63:32]   = (mode_pass ? sr : fr) & OUT_MASK;
    out_data_nxt[95:64]   = (lp_r ? ctr : '0) & OUT_MASK;
    out_data_nxt[127:96]  = sl & OUT_MASK;
    out_data_nxt[159:128] = sr & OUT_MASK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (stat.out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.out_load) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // sequencer is idle right after reset
  a_idle_after_reset: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("sequencer not idle after reset");

  // an accepted frame moves the sequencer off its idle step
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_tready)
    else $error("frame accepted but sequencer stayed idle");

  // loading a result returns to idle and presents the result
  a_load_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    stat.out_load |=> (out_tvalid && in_tready))
    else $error("result load did not present data or return to idle");

endmodule

// File: dv/testbench.sv
module testbench;

  localparam int SAMPLE_BITS = 32;

  // register indexes on the cfg_ port
  localparam logic [1:0] REG_LOWPASS   = 2'd0;
  localparam logic [1:0] REG_HP_BYPASS = 2'd1;
  localparam logic [1:0] REG_GAIN      = 2'd2;
  localparam logic [1:0] REG_UNUSED    = 2'd3;

  localparam upmx_pkg::q31_t Q31_TOP    = 32'sh7fff_ffff;
  localparam upmx_pkg::q31_t Q31_BOTTOM = 32'sh8000_0000;
  localparam upmx_pkg::q31_t GAIN_HALF  = 32'sh4000_0000;

  localparam int RANDOM_FRAMES = 650;
  localparam int DRAIN_CYCLES  = 60;
  localparam int REPORT_CAP    = 25;

  // one result word, same layout as out_tdata:
  // front_left, front_right, center_out, surround_left, surround_right (LSB up)
  typedef logic [159:0] upmix_word_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [63:0]  in_tdata   = '0;   // left_sample, right_sample
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [159:0] out_tdata;         // front_left, front_right, center_out,
                                   // surround_left, surround_right
  logic         cfg_valid  = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index  = '0;
  logic [31:0]  cfg_data   = '0;

  stereo_to_five_channel_biquad_upmix_unit #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the five tap sets and the registers.
  // Taps per filter: [0] x(n-1), [1] x(n-2), [2] y(n-1), [3] y(n-2).
  // Rows are indexed by the package filter ids.
  // ---------------------------------------------------------------------------
  upmx_pkg::q31_t taps [upmx_pkg::NUM_FILT][upmx_pkg::NUM_TAPS];
  logic lp_on;
  logic hp_bypass;
  upmx_pkg::q31_t gain;

  upmix_word_t pending_frames [$];   // expected results, oldest first

  bit steady = 1'b0;   // when set, neither side idles
  int stall_left = 0;

  int n_errors = 0;
  int n_frames = 0;
  int n_checked = 0;
  int n_cfg_writes = 0;
  int n_lowpass = 0;
  int n_highpass = 0;
  int n_pass = 0;

  function automatic upmx_pkg::q31_t clamp_q31(input longint v);
    upmx_pkg::q31_t r;
    if (v > longint'(Q31_TOP)) r = Q31_TOP;
    else if (v < longint'(Q31_BOTTOM)) r = Q31_BOTTOM;
    else r = upmx_pkg::q31_t'(v);
    return r;
  endfunction

  // Q1.31 x Q1.31: exact product, arithmetic shift by 31 (floor), then clamp.
  // Only -1 * -1 actually clamps.
  function automatic upmx_pkg::q31_t frac_mul(input upmx_pkg::q31_t a,
                                              input upmx_pkg::q31_t b);
    longint p;
    p = longint'(a) * longint'(b);
    return clamp_q31(p >>> 31);
  endfunction

  // Halved coefficient table, Q1.31.
  function automatic upmx_pkg::q31_t half_coef(input logic lowpass, input logic [2:0] idx);
    upmx_pkg::q31_t c;
    c = '0;
    case ({lowpass, idx})
      {1'b1, upmx_pkg::C_A0}, {1'b1, upmx_pkg::C_A2}: c = 32'sd4952781;
      {1'b1, upmx_pkg::C_A1}:                         c = 32'sd9905562;
      {1'b1, upmx_pkg::C_B1}:                         c = -32'sd1931765060;
      {1'b1, upmx_pkg::C_B2}:                         c = 32'sd877797259;
      {1'b0, upmx_pkg::C_A0}, {1'b0, upmx_pkg::C_A2}: c = 32'sd1020910595;
      {1'b0, upmx_pkg::C_A1}:                         c = -32'sd2041821189;
      {1'b0, upmx_pkg::C_B1}:                         c = -32'sd2039393731;
      {1'b0, upmx_pkg::C_B2}:                         c = 32'sd970837673;
      default:                                        c = '0;
    endcase
    return c;
  endfunction

  // Direct form 1, every product counted twice; exact sum, clamped once.
  function automatic upmx_pkg::q31_t run_biquad(input upmx_pkg::q31_t x,
                                                input logic lowpass,
                                                input upmx_pkg::filt_t f);
    longint acc;
    upmx_pkg::q31_t y;
    acc = 2 * longint'(frac_mul(half_coef(lowpass, upmx_pkg::C_A0), x))
        + 2 * longint'(frac_mul(half_coef(lowpass, upmx_pkg::C_A1), taps[f][0]))
        + 2 * longint'(frac_mul(half_coef(lowpass, upmx_pkg::C_A2), taps[f][1]))
        - 2 * longint'(frac_mul(half_coef(lowpass, upmx_pkg::C_B1), taps[f][2]))
        - 2 * longint'(frac_mul(half_coef(lowpass, upmx_pkg::C_B2), taps[f][3]));
    y = clamp_q31(acc);
    taps[f][3] = taps[f][2];
    taps[f][2] = y;
    taps[f][1] = taps[f][0];
    taps[f][0] = x;
    return y;
  endfunction

  // Reduced precision builds clear the low bits of every output word.
  function automatic upmx_pkg::q31_t port_word(input upmx_pkg::q31_t v);
    return v & ~((32'd1 << (32 - SAMPLE_BITS)) - 32'd1);
  endfunction

  // Work out the result of one accepted frame and queue it.
  task automatic predict_upmix(input upmx_pkg::q31_t left, input upmx_pkg::q31_t right);
    upmx_pkg::q31_t sl;
    upmx_pkg::q31_t sr;
    upmx_pkg::q31_t fl;
    upmx_pkg::q31_t fr;
    upmx_pkg::q31_t ctr;
    sl  = frac_mul(left, gain);
    sr  = frac_mul(right, gain);
    ctr = '0;   // center stays zero and its taps frozen outside lowpass
    if (lp_on) begin
      fl  = run_biquad(sl, 1'b1, upmx_pkg::F_LPL);
      ctr = run_biquad(sl, 1'b1, upmx_pkg::F_LPC);
      fr  = run_biquad(sr, 1'b1, upmx_pkg::F_LPR);
      n_lowpass++;
    end else if (!hp_bypass) begin
      fl = run_biquad(sl, 1'b0, upmx_pkg::F_HPL);
      fr = run_biquad(sr, 1'b0, upmx_pkg::F_HPR);
      n_highpass++;
    end else begin
      fl = sl;
      fr = sr;
      n_pass++;
    end
    pending_frames.push_back({port_word(sr), port_word(sl), port_word(ctr),
                              port_word(fr), port_word(fl)});
  endtask

  // ---------------------------------------------------------------------------
  // Idle lengths: mostly none, often short, now and then long.
  // ---------------------------------------------------------------------------
  function automatic int idle_len();
    int unsigned r;
    int n;
    n = 0;
    if (!steady) begin
      r = $urandom_range(0, 99);
      if (r >= 92) n = $urandom_range(12, 40);
      else if (r >= 55) n = $urandom_range(1, 3);
    end
    return n;
  endfunction

  // Result side back-pressure.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = idle_len();
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each out_ transaction against the oldest expectation.
  // ---------------------------------------------------------------------------
  function automatic string field_name(input int k);
    string s;
    case (k)
      0:       s = "front_left";
      1:       s = "front_right";
      2:       s = "center_out";
      3:       s = "surround_left";
      default: s = "surround_right";
    endcase
    return s;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    n_errors++;
    if (n_errors <= REPORT_CAP)
      $display("ERROR @%0t result #%0d %s: expected %h got %h",
               $time, n_checked, what, want, got);
  endtask

  upmix_word_t oldest;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_frames.size() == 0) begin
        report_mismatch("unexpected result", '0, out_tdata[31:0]);
      end else begin
        oldest = pending_frames.pop_front();
        for (int k = 0; k < 5; k++) begin
          if (out_tdata[32*k +: 32] !== oldest[32*k +: 32])
            report_mismatch(field_name(k), oldest[32*k +: 32], out_tdata[32*k +: 32]);
        end
      end
      n_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. A valid left high after its transaction is only lowered when
  // the next one waits, so a signal never sees two assignments in one step.
  // ---------------------------------------------------------------------------
  task automatic send_frame(input upmx_pkg::q31_t left, input upmx_pkg::q31_t right);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {right, left};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_upmix(left, right);
    n_frames++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      cfg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_LOWPASS:   lp_on = value[0];
      REG_HP_BYPASS: hp_bypass = value[0];
      REG_GAIN:      gain = value;
      default: ;   // out of range, ignored
    endcase
    n_cfg_writes++;
  endtask

  // All three registers; upper bits of the 1-bit ones are don't-care.
  task automatic configure(input logic lowpass, input logic bypass, input upmx_pkg::q31_t g);
    write_reg(REG_LOWPASS, {31'($urandom), lowpass});
    write_reg(REG_HP_BYPASS, {31'($urandom), bypass});
    write_reg(REG_GAIN, g);
    cfg_valid <= 1'b0;
  endtask

  // Hold off the sender until every expected result is back (block idle).
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_frames.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic upmx_pkg::q31_t pick_sample(input upmx_pkg::q31_t prev);
    int unsigned r;
    logic [15:0] h;
    upmx_pkg::q31_t v;
    r = $urandom_range(0, 99);
    h = 16'($urandom);
    if (r < 40) begin
      v = $urandom;
    end else if (r < 55) begin
      case ($urandom_range(0, 4))
        0:       v = Q31_TOP;
        1:       v = Q31_BOTTOM;
        2:       v = '0;
        3:       v = -32'sd1;
        default: v = 32'sd1;
      endcase
    end else if (r < 75) begin
      v = {{16{h[15]}}, h};
    end else begin
      // slow drift around the last value, lets the filters ring
      v = prev + upmx_pkg::q31_t'($urandom_range(0, 4000)) - 32'sd2000;
    end
    return v;
  endfunction

  function automatic upmx_pkg::q31_t pick_gain();
    upmx_pkg::q31_t g;
    case ($urandom_range(0, 6))
      0:       g = Q31_TOP;
      1:       g = Q31_BOTTOM;
      2:       g = '0;
      3:       g = GAIN_HALF;
      4:       g = -GAIN_HALF;
      default: g = $urandom;
    endcase
    return g;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: lowpass on, gain one half. Field extremes.
  task automatic test_reset_defaults();
    send_frame('0, '0);
    send_frame(Q31_TOP, Q31_BOTTOM);
    send_frame(Q31_BOTTOM, Q31_TOP);
    send_frame(-32'sd1, 32'sd1);
    send_frame(Q31_TOP, Q31_TOP);
  endtask

  // Pass mode with extreme gains; minus one times minus one must clamp.
  task automatic test_pass_saturation();
    settle();
    configure(1'b0, 1'b1, Q31_BOTTOM);
    send_frame(Q31_BOTTOM, Q31_BOTTOM);
    send_frame(Q31_TOP, Q31_BOTTOM);
    send_frame('0, 32'sd1);
    settle();
    configure(1'b0, 1'b1, Q31_TOP);
    send_frame(Q31_BOTTOM, Q31_TOP);
    send_frame(Q31_TOP, -32'sd1);
  endtask

  // Highpass with full-scale steps; drives the accumulator into clamping.
  task automatic test_highpass_steps();
    settle();
    configure(1'b0, 1'b0, Q31_TOP);
    repeat (4) send_frame(Q31_TOP, Q31_BOTTOM);
    repeat (2) send_frame(Q31_BOTTOM, Q31_TOP);
  endtask

  // Lowpass -> highpass -> lowpass: taps must survive the mode changes,
  // center reads zero outside lowpass. Bypass set with lowpass on is ignored.
  task automatic test_state_persistence();
    settle();
    configure(1'b1, 1'b0, GAIN_HALF);
    send_frame(32'sh1234_5678, -32'sh0765_4321);
    send_frame(32'sh4000_0000, 32'sh3000_0000);
    settle();
    configure(1'b0, 1'b0, GAIN_HALF);
    send_frame(32'sh2000_0000, -32'sh2000_0000);
    send_frame(-32'sh1000_0000, 32'sh1000_0000);
    settle();
    configure(1'b1, 1'b1, -GAIN_HALF);
    send_frame(32'sh0fff_ffff, 32'sh7000_0000);
    send_frame(Q31_BOTTOM, 32'sh0000_8000);
  endtask

  // A write to the spare index must change nothing.
  task automatic test_unused_index();
    settle();
    write_reg(REG_UNUSED, $urandom);
    cfg_valid <= 1'b0;
    send_frame(32'sh5555_5555, 32'shAAAA_AAAA);
    send_frame(32'shAAAA_AAAA, 32'sh5555_5555);
  endtask

  // Random phases: random register settings, bursts of frames with
  // random content, some bursts with no idling on either side.
  task automatic test_random_phases();
    int sent;
    int len;
    upmx_pkg::q31_t pl;
    upmx_pkg::q31_t pr;
    sent = 0;
    pl = '0;
    pr = '0;
    while (sent < RANDOM_FRAMES) begin
      settle();
      steady = ($urandom_range(0, 4) == 0);
      configure(1'($urandom), 1'($urandom), pick_gain());
      len = $urandom_range(8, 60);
      if (len > RANDOM_FRAMES - sent) len = RANDOM_FRAMES - sent;
      repeat (len) begin
        pl = pick_sample(pl);
        pr = pick_sample(pr);
        send_frame(pl, pr);
      end
      sent += len;
    end
    steady = 1'b0;
  endtask

  // Run limit, far above the slowest legal run.
  initial begin
    #5_000_000;
    $display("stereo_to_five_channel_biquad_upmix_unit: mismatch");
    $finish;
  end

  initial begin
    for (int f = 0; f < upmx_pkg::NUM_FILT; f++)
      for (int t = 0; t < upmx_pkg::NUM_TAPS; t++)
        taps[f][t] = '0;
    lp_on     = 1'b1;
    hp_bypass = 1'b0;
    gain      = GAIN_HALF;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_pass_saturation();
    test_highpass_steps();
    test_state_persistence();
    test_unused_index();
    test_random_phases();

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);   // catch any stray result

    $display("covered %0d frames (%0d lowpass, %0d highpass, %0d pass), %0d reg writes",
             n_frames, n_lowpass, n_highpass, n_pass, n_cfg_writes);
    $display("checked %0d results, %0d field errors", n_checked, n_errors);
    if (n_errors == 0 && pending_frames.size() == 0) begin
      $display("stereo_to_five_channel_biquad_upmix_unit: match");
    end else begin
      $display("stereo_to_five_channel_biquad_upmix_unit: mismatch");
    end
    $finish;
  end

endmodule
